/* rtl/lsof_pkg.sv */
`timescale 1ns / 1ps

package lsof_pkg;

    // Scan geometry
    localparam int SAMPLES_PER_SCAN = 640;
    localparam int SECTORS          = 8;
    localparam int SECTION          = (SAMPLES_PER_SCAN / SECTORS == 0) ? 1
                                      : SAMPLES_PER_SCAN / SECTORS;
    localparam int OFFSET_W         = (SECTION > 1) ? $clog2(SECTION) : 1;
    localparam int SECTOR_IDX_W     = $clog2(SECTORS + 1);

    // Field widths
    localparam int RANGE_W  = 16;
    localparam int COUNT_W  = 10;
    localparam int TOL_W    = 10;
    localparam int STEPS_W  = 8;
    localparam int SUM_W    = COUNT_W + 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int OUT_DATA_W = 8;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
    localparam logic [STEPS_W-1:0] STEPS_MAX = '1;

    // Reset values of the configuration registers
    localparam logic [RANGE_W-1:0] RANGE_THRESHOLD_RST = 16'd1000;
    localparam logic [TOL_W-1:0]   SIMILARITY_TOL_RST  = 10'd5;
    localparam logic [STEPS_W-1:0] MAX_CLEAR_STEPS_RST = 8'd2;

    typedef logic [COUNT_W-1:0] count_t;
    typedef count_t [SECTORS-1:0] count_vec_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_RANGE_THRESHOLD = 2'd0,
        REG_SIMILARITY_TOL  = 2'd1,
        REG_MAX_CLEAR_STEPS = 2'd2
    } cfg_reg_t;

    typedef enum logic [1:0] {
        MODE_SCANNING = 2'd0,
        MODE_SAMPLING = 2'd1,
        MODE_STATIC   = 2'd2,
        MODE_DYNAMIC  = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        CMD_NONE  = 3'd0,
        CMD_STOP  = 3'd1,
        CMD_STEP  = 3'd2,
        CMD_LEFT  = 3'd3,
        CMD_RIGHT = 3'd4
    } cmd_t;

    // One processed sample as seen by the sector counters
    typedef struct packed {
        logic fire;
        logic below;
        logic last;
    } sample_ctl_t;

    // Result beat, lowest bits last in this list
    typedef struct packed {
        logic  pad;
        logic  obstacle_seen;
        logic  obstacle_active;
        mode_t mode;
        cmd_t  command;
    } out_beat_t;

endpackage

/* rtl/lsof_sectors.sv */
`timescale 1ns / 1ps

module lsof_sectors
    import lsof_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  sample_ctl_t sample,
    output count_vec_t  counts_upd,
    output logic        seen
);

    count_vec_t                counts_reg;
    logic [SECTOR_IDX_W-1:0]   idx_reg;
    logic [OFFSET_W-1:0]       offset_reg;
    logic                      in_scan;
    logic                      hit;
    logic [SECTORS-1:0]        nonzero;

    // Sectors past the last one are not counted
    assign in_scan = idx_reg < SECTOR_IDX_W'(SECTORS);
    assign hit     = sample.fire && sample.below && in_scan;

    // Add the current sample to its sector, saturating
    for (genvar i = 0; i < SECTORS; i++) begin : g_count
        assign counts_upd[i] = counts_reg[i] + COUNT_W'(hit
                               && (idx_reg == SECTOR_IDX_W'(i))
                               && (counts_reg[i] != COUNT_MAX));
        assign nonzero[i] = |counts_upd[i];
    end

    assign seen = |nonzero;

    // Advance position; clear everything at the end of a scan
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            counts_reg <= '0;
            idx_reg    <= '0;
            offset_reg <= '0;
        end
        else if (sample.fire)
        begin
            if (sample.last)
            begin
                counts_reg <= '0;
                idx_reg    <= '0;
                offset_reg <= '0;
            end
            else
            begin
                counts_reg <= counts_upd;
                if (in_scan)
                begin
                    if (offset_reg == OFFSET_W'(SECTION - 1))
                    begin
                        offset_reg <= '0;
                        idx_reg    <= idx_reg + 1'b1;
                    end
                    else
                    begin
                        offset_reg <= offset_reg + 1'b1;
                    end
                end
            end
        end
    end

endmodule

/* rtl/lidar_sector_obstacle_fsm.sv */
`timescale 1ns / 1ps

// Lidar sector obstacle machine.
// s_axis carries one range sample per beat: tdata holds the range in mm,
// tuser the vehicle-moving flag, tlast marks the final sample of a scan.
// Samples below the range threshold are counted in one of eight sectors by
// their position in the scan. Only the tlast beat produces a result on
// m_axis, whose tdata holds {seen, active, mode, command} from bit 6 down.
// cfg_* writes the threshold (index 0), similarity tolerance (1) and
// forward steps after clearing (2); cfg_ready is always high.
// Throughput: one sample per cycle while no result is stalled on m_axis. A
// beat is registered on acceptance and processed once no result is stalled,
// and the result of its tlast beat is registered in the output stage. The
// sector counters and the machine are updated in that one processing stage.
// Reset clears the counters, scan position, machine (scanning) and the
// configuration to its defaults. While a result waits on m_axis the block
// still takes one more sample into its input register, then holds
// s_axis_tready low until the result is taken.

module lidar_sector_obstacle_fsm
    import lsof_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [RANGE_W-1:0]    s_axis_tdata,   // [15:0] range_mm
    input  logic                  s_axis_tuser,   // [0] vehicle_moving
    input  logic                  s_axis_tlast,   // last_in_scan
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata,   // [2:0] command, [4:3] mode,
                                                  // [5] obstacle_active,
                                                  // [6] obstacle_seen, [7] zero
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    // Configuration
    logic [RANGE_W-1:0] thresh_reg;
    logic [TOL_W-1:0]   tol_reg;
    logic [STEPS_W-1:0] max_steps_reg;

    // Input stage
    logic               in_valid_reg;
    logic [RANGE_W-1:0] in_range_reg;
    logic               in_moving_reg;
    logic               in_last_reg;

    // Machine state
    mode_t              mode_reg, mode_next, eff_mode;
    logic               flag_reg, flag_next;
    logic               snap_reg, snap_next;
    logic [STEPS_W-1:0] steps_reg, steps_next;
    count_vec_t         saved_reg;
    logic               save_en;
    cmd_t               cmd;

    // Output stage
    logic               out_valid_reg;
    out_beat_t          out_beat_reg;

    logic               stall;
    logic               advance;
    logic               step_fire;
    sample_ctl_t        sample;
    count_vec_t         counts_upd;
    logic               seen;
    logic               similar;
    logic [SUM_W-1:0]   sum_low;
    logic [SUM_W-1:0]   sum_high;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thresh_reg    <= RANGE_THRESHOLD_RST;
            tol_reg       <= SIMILARITY_TOL_RST;
            max_steps_reg <= MAX_CLEAR_STEPS_RST;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_RANGE_THRESHOLD: thresh_reg    <= cfg_data;
                REG_SIMILARITY_TOL:  tol_reg       <= cfg_data[TOL_W-1:0];
                REG_MAX_CLEAR_STEPS: max_steps_reg <= cfg_data[STEPS_W-1:0];
                default: ;
            endcase
        end
    end

    // Handshake: the input stage moves on whenever the output slot is free
    assign stall         = out_valid_reg && !m_axis_tready;
    assign advance       = in_valid_reg && !stall;
    assign step_fire     = advance && in_last_reg;
    assign s_axis_tready = !in_valid_reg || !stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_axis_tready)
            in_valid_reg <= s_axis_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_range_reg  <= s_axis_tdata;
            in_moving_reg <= s_axis_tuser;
            in_last_reg   <= s_axis_tlast;
        end
    end

    // Sector counting
    assign sample.fire  = advance;
    assign sample.below = in_range_reg < thresh_reg;
    assign sample.last  = in_last_reg;

    lsof_sectors u_sectors (
        .clk        (clk),
        .rst_n      (rst_n),
        .sample     (sample),
        .counts_upd (counts_upd),
        .seen       (seen)
    );

    // Compare against the snapshot, sector by sector
    always_comb
    begin
        logic [COUNT_W-1:0] diff;
        similar = 1'b1;
        for (int i = 0; i < SECTORS; i++)
        begin
            diff = (saved_reg[i] > counts_upd[i]) ? saved_reg[i] - counts_upd[i]
                                                  : counts_upd[i] - saved_reg[i];
            if (diff > tol_reg)
                similar = 1'b0;
        end
    end

    // Lower and upper half sums pick the rotation direction
    assign sum_low  = SUM_W'(counts_upd[0]) + SUM_W'(counts_upd[1])
                    + SUM_W'(counts_upd[2]) + SUM_W'(counts_upd[3]);
    assign sum_high = SUM_W'(counts_upd[4]) + SUM_W'(counts_upd[5])
                    + SUM_W'(counts_upd[6]) + SUM_W'(counts_upd[7]);

    // Machine: next state and command on the last sample of a scan
    always_comb
    begin
        mode_next  = mode_reg;
        flag_next  = flag_reg;
        snap_next  = snap_reg;
        steps_next = steps_reg;
        eff_mode   = mode_reg;
        save_en    = 1'b0;
        cmd        = CMD_NONE;
        if (step_fire)
        begin
            if (seen && mode_reg == MODE_SCANNING)
            begin
                eff_mode  = MODE_SAMPLING;
                flag_next = 1'b1;
            end
            mode_next = eff_mode;
            unique case (eff_mode)
                MODE_SCANNING: ;
                MODE_SAMPLING:
                begin
                    cmd = CMD_STOP;
                    if (!in_moving_reg)
                    begin
                        if (!snap_reg)
                        begin
                            save_en   = 1'b1;
                            snap_next = 1'b1;
                        end
                        else
                        begin
                            mode_next = similar ? MODE_STATIC : MODE_DYNAMIC;
                            snap_next = 1'b0;
                        end
                    end
                end
                MODE_STATIC:
                begin
                    if (seen)
                    begin
                        steps_next = '0;
                        if ((|counts_upd[0]) && (|counts_upd[SECTORS-1]))
                            cmd = CMD_STEP;
                        else
                            cmd = (sum_low > sum_high) ? CMD_LEFT : CMD_RIGHT;
                    end
                    else
                    begin
                        if (steps_reg != STEPS_MAX)
                            steps_next = steps_reg + 1'b1;
                        if (steps_reg < max_steps_reg)
                        begin
                            cmd = CMD_STEP;
                        end
                        else
                        begin
                            flag_next = 1'b0;
                            mode_next = MODE_SCANNING;
                        end
                    end
                end
                MODE_DYNAMIC:
                begin
                    if (seen)
                    begin
                        cmd       = CMD_STOP;
                        mode_next = MODE_SAMPLING;
                    end
                    else
                    begin
                        flag_next = 1'b0;
                        mode_next = MODE_SCANNING;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_SCANNING;
            flag_reg  <= 1'b0;
            snap_reg  <= 1'b0;
            steps_reg <= '0;
        end
        else
        begin
            mode_reg  <= mode_next;
            flag_reg  <= flag_next;
            snap_reg  <= snap_next;
            steps_reg <= steps_next;
        end
    end

    // Snapshot of the sector counts
    always_ff @(posedge clk)
    begin
        if (save_en)
            saved_reg <= counts_upd;
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (step_fire)
            out_valid_reg <= 1'b1;
        else if (m_axis_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (step_fire)
        begin
            out_beat_reg.pad             <= 1'b0;
            out_beat_reg.obstacle_seen   <= seen;
            out_beat_reg.obstacle_active <= flag_next;
            out_beat_reg.mode            <= mode_next;
            out_beat_reg.command         <= cmd;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_beat_reg;

endmodule

/* rtl/lsof_checker.sv */
`timescale 1ns / 1ps

module lsof_checker
    import lsof_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  s_axis_tvalid,
    input logic                  s_axis_tready,
    input logic [RANGE_W-1:0]    s_axis_tdata,
    input logic                  s_axis_tuser,
    input logic                  s_axis_tlast,
    input logic                  m_axis_tvalid,
    input logic                  m_axis_tready,
    input logic [OUT_DATA_W-1:0] m_axis_tdata,
    input logic                  cfg_valid,
    input logic                  cfg_ready,
    input logic [CFG_IDX_W-1:0]  cfg_index,
    input logic [CFG_DATA_W-1:0] cfg_data
);

    out_beat_t beat;
    assign beat = out_beat_t'(m_axis_tdata);

    // Hold a stalled result beat
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result beat changed while stalled");

    // Obstacle flag is set exactly when the machine is out of scanning
    a_flag_mode: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (beat.obstacle_active == (beat.mode != MODE_SCANNING)))
        else $error("obstacle flag disagrees with mode");

    // Sampling always stops the vehicle
    a_sampling_stop: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && beat.mode == MODE_SAMPLING |-> beat.command == CMD_STOP)
        else $error("sampling mode without stop command");

    // Rotation only while holding a static obstacle in view
    a_rotate_static: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (beat.command == CMD_LEFT || beat.command == CMD_RIGHT)
        |-> beat.mode == MODE_STATIC && beat.obstacle_seen)
        else $error("rotation outside static mode with obstacle");

endmodule

bind lidar_sector_obstacle_fsm lsof_checker u_lsof_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
);
